// ===== rtl/core/vcfe_pkg.sv =====
`default_nettype none
package vcfe_pkg;
  localparam int Edge = 8;
  localparam int Rows = Edge * Edge;

  typedef enum logic [3:0] {
    CMD_CLEAR  = 4'd0,
    CMD_FILL   = 4'd1,
    CMD_SET    = 4'd2,
    CMD_UNSET  = 4'd3,
    CMD_TEST   = 4'd4,
    CMD_PLANE  = 4'd5,
    CMD_SHIFT  = 4'd6,
    CMD_EDGES  = 4'd7,
    CMD_RENDER = 4'd8
  } cmd_t;

  localparam logic [2:0] DIR_PX = 3'd0;
  localparam logic [2:0] DIR_NX = 3'd1;
  localparam logic [2:0] DIR_PZ = 3'd2;
  localparam logic [2:0] DIR_NZ = 3'd3;
  localparam logic [2:0] DIR_PY = 3'd4;
  localparam logic [2:0] DIR_NY = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       load;
    logic       sweep;
    logic       probe;
    logic       gather;
    logic       single;
    logic       emit;
    logic [5:0] step;
    logic [2:0] layer;
  } ctl_t;

  typedef struct packed {
    logic [3:0] command;
    logic [2:0] x_coord;
    logic [2:0] y_coord;
    logic [2:0] z_coord;
    logic [1:0] plane_axis;
    logic [2:0] plane_index;
    logic [2:0] direction;
    logic [3:0] edge_length;
  } item_t;
endpackage
`default_nettype wire

// ===== rtl/core/vcfe_ctrl.sv =====
`default_nettype none
module vcfe_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [3:0]   command,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_last,
  output vcfe_pkg::ctl_t    ctl
);
  import vcfe_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SWEEP  = 6'b000010,
    S_PROBE  = 6'b000100,
    S_TEST   = 6'b001000,
    S_GATHER = 6'b010000,
    S_RENDER = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [5:0] step, step_next;
  logic [2:0] layer, layer_next;
  logic       fire;

  assign fire     = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    layer_next = layer;
    ctl        = '0;
    ctl.step   = step;
    ctl.layer  = layer;
    ctl.load   = fire;
    out_valid  = 1'b0;
    out_last   = 1'b0;
    unique case (state)
      S_IDLE: begin
        step_next  = '0;
        layer_next = '0;
        if (fire) begin
          if (command == CMD_RENDER) state_next = S_GATHER;
          else if (command == CMD_TEST) state_next = S_PROBE;
          else state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        ctl.sweep = 1'b1;
        step_next = step + 6'd1;
        if (step == 6'(Rows - 1)) state_next = S_IDLE;
      end
      S_PROBE: begin
        ctl.probe  = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        out_valid  = 1'b1;
        out_last   = 1'b1;
        ctl.single = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      S_GATHER: begin
        ctl.gather = 1'b1;
        step_next  = step + 6'd1;
        if (step == 6'(Edge - 1)) begin
          step_next  = '0;
          state_next = S_RENDER;
        end
      end
      S_RENDER: begin
        out_valid = 1'b1;
        ctl.emit  = 1'b1;
        out_last  = (layer == 3'(Edge - 1));
        if (out_ready) begin
          layer_next = layer + 3'd1;
          if (out_last) state_next = S_IDLE;
          else state_next = S_GATHER;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      step  <= '0;
      layer <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      layer <= layer_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/vcfe_datapath.sv =====
`default_nettype none
module vcfe_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire vcfe_pkg::ctl_t ctl,
  input  wire vcfe_pkg::item_t item,
  output logic [7:0]          layer_select,
  output logic [7:0]          byte_a,
  output logic [7:0]          byte_b,
  output logic [7:0]          byte_c,
  output logic [7:0]          byte_d,
  output logic [7:0]          byte_e,
  output logic [7:0]          byte_f,
  output logic [7:0]          byte_g,
  output logic [7:0]          byte_h,
  output logic                voxel_on
);
  import vcfe_pkg::*;

  logic [7:0] rows [Rows];
  logic [7:0] fb [Edge];
  item_t      cur;
  logic [7:0] rd_q;
  logic [5:0] dst_q;
  logic       zero_q;
  logic       wr_q;
  logic [5:0] dst, src, raddr;
  logic       zero;
  logic [7:0] old, nrow, edge_mask;

  always_comb begin
    logic shifting;
    shifting = (cur.command == CMD_SHIFT);
    if (shifting && (cur.direction == DIR_NZ || cur.direction == DIR_NY)) dst = ~ctl.step;
    else dst = ctl.step;
    src  = dst;
    zero = 1'b0;
    if (shifting) begin
      if (cur.direction == DIR_PZ) begin
        src  = dst + 6'd1;
        zero = (dst[2:0] == 3'(Edge - 1));
      end else if (cur.direction == DIR_NZ) begin
        src  = dst - 6'd1;
        zero = (dst[2:0] == 3'd0);
      end else if (cur.direction == DIR_PY) begin
        src  = dst + 6'(Edge);
        zero = (dst[5:3] == 3'(Edge - 1));
      end else if (cur.direction == DIR_NY) begin
        src  = dst - 6'(Edge);
        zero = (dst[5:3] == 3'd0);
      end
    end
    if (ctl.probe) raddr = {~cur.y_coord, ~cur.z_coord};
    else if (ctl.gather) raddr = {~ctl.layer, ctl.step[2:0]};
    else raddr = src;
  end

  always_comb begin
    logic [4:0] e, xs, xe, ys, ye, zs, ze, y, z;
    logic [7:0] xline, xends;
    logic       yend, yin, zend, zin;
    e  = {1'b0, cur.edge_length} - 5'd1;
    xs = {2'b00, cur.x_coord};
    ys = {2'b00, cur.y_coord};
    zs = {2'b00, cur.z_coord};
    xe = xs + e;
    ye = ys + e;
    ze = zs + e;
    y  = {2'b00, ~dst_q[5:3]};
    z  = {2'b00, ~dst_q[2:0]};
    xline = '0;
    xends = '0;
    for (int b = 0; b < Edge; b++) begin
      if (5'(b) >= xs && 5'(b) <= xe) xline[b] = 1'b1;
      if (5'(b) == xs || 5'(b) == xe) xends[b] = 1'b1;
    end
    yend = (y == ys) || (y == ye);
    zend = (z == zs) || (z == ze);
    yin  = (y >= ys) && (y <= ye);
    zin  = (z >= zs) && (z <= ze);
    edge_mask = '0;
    if (cur.edge_length != 4'd0) begin
      if (yend && zend) edge_mask = edge_mask | xline;
      if ((yend && zin) || (yin && zend)) edge_mask = edge_mask | xends;
    end
  end

  always_comb begin
    logic [2:0] y, z;
    y    = ~dst_q[5:3];
    z    = ~dst_q[2:0];
    old  = zero_q ? 8'd0 : rd_q;
    nrow = old;
    unique case (cur.command)
      CMD_CLEAR: nrow = '0;
      CMD_FILL:  nrow = 8'hFF;
      CMD_SET:   if (y == cur.y_coord && z == cur.z_coord)
                   nrow = old | (8'd1 << cur.x_coord);
      CMD_UNSET: if (y == cur.y_coord && z == cur.z_coord)
                   nrow = old & ~(8'd1 << cur.x_coord);
      CMD_PLANE: begin
        if (cur.plane_axis == AXIS_X) nrow = old | (8'd1 << cur.plane_index);
        else if (cur.plane_axis == AXIS_Y && y == cur.plane_index) nrow = 8'hFF;
        else if (cur.plane_axis == AXIS_Z && z == cur.plane_index) nrow = 8'hFF;
      end
      CMD_SHIFT: begin
        if (cur.direction == DIR_PX) nrow = old << 1;
        else if (cur.direction == DIR_NX) nrow = old >> 1;
      end
      CMD_EDGES: nrow = old | edge_mask;
      default:   nrow = old;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= '0;
      wr_q <= 1'b0;
    end else begin
      if (ctl.load) cur <= item;
      wr_q <= ctl.sweep;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sweep) begin
      dst_q  <= dst;
      zero_q <= zero;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_q) rows[dst_q] <= nrow;
    if (ctl.sweep || ctl.probe) rd_q <= rows[raddr];
    if (ctl.gather) fb[ctl.step[2:0]] <= rows[raddr];
  end

  always_comb begin
    voxel_on     = ctl.single ? rd_q[cur.x_coord] : 1'b0;
    layer_select = ctl.emit ? (8'd1 << ctl.layer) : 8'd0;
    byte_a = ctl.emit ? fb[1] : 8'd0;
    byte_b = ctl.emit ? fb[0] : 8'd0;
    byte_c = ctl.emit ? fb[3] : 8'd0;
    byte_d = ctl.emit ? fb[2] : 8'd0;
    byte_e = ctl.emit ? fb[5] : 8'd0;
    byte_f = ctl.emit ? fb[4] : 8'd0;
    byte_g = ctl.emit ? fb[7] : 8'd0;
    byte_h = ctl.emit ? fb[6] : 8'd0;
  end
endmodule
`default_nettype wire

// ===== rtl/core/voxel_cube_frame_engine_top.sv =====
// Edit commands: accept cycle, then a row sweep over all 64 rows.
// Test: result valid in the test state after the probe read, held until taken.
// Render: per layer 8 row reads, then the frame held until taken.
// One command at a time, set by the controller state machine.
// Reset (rst, synchronous) starts a clearing sweep over all 64 rows of the voxel store;
// input stalls until it ends.
`default_nettype none
module voxel_cube_frame_engine_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] command,
  input  wire logic [2:0] x_coord,
  input  wire logic [2:0] y_coord,
  input  wire logic [2:0] z_coord,
  input  wire logic [1:0] plane_axis,
  input  wire logic [2:0] plane_index,
  input  wire logic [2:0] direction,
  input  wire logic [3:0] edge_length,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      layer_select,
  output logic [7:0]      byte_a,
  output logic [7:0]      byte_b,
  output logic [7:0]      byte_c,
  output logic [7:0]      byte_d,
  output logic [7:0]      byte_e,
  output logic [7:0]      byte_f,
  output logic [7:0]      byte_g,
  output logic [7:0]      byte_h,
  output logic            voxel_on,
  output logic            last
);
  import vcfe_pkg::*;

  ctl_t  ctl;
  item_t item;

  assign item = '{command, x_coord, y_coord, z_coord, plane_axis,
                  plane_index, direction, edge_length};

  vcfe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .command(command),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .out_last(last), .ctl(ctl)
  );

  vcfe_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .item(item),
    .layer_select(layer_select), .byte_a(byte_a), .byte_b(byte_b),
    .byte_c(byte_c), .byte_d(byte_d), .byte_e(byte_e), .byte_f(byte_f),
    .byte_g(byte_g), .byte_h(byte_h), .voxel_on(voxel_on)
  );
endmodule
`default_nettype wire
